/* hdl/dq_pkg.sv */
// ----------------------------------------------------------------------------
// dq_pkg
// Types and constants shared by the double-ended queue core and its parts.
// ----------------------------------------------------------------------------
package dq_pkg;

   localparam int DEPTH   = 16;
   localparam int PTR_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int DATA_W  = 32;
   localparam int CMD_W   = 3;
   localparam int STAT_W  = 2;

   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_PEEK_FRONT = 3'd4;
   localparam logic [CMD_W-1:0] CMD_PEEK_BACK  = 3'd5;

   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;

   typedef struct packed {
      logic              we;
      logic [PTR_W-1:0]  addr;
      logic [DATA_W-1:0] wdata;
   } mem_req_type;

   typedef struct packed {
      logic              valid;
      logic              rd;
      logic [STAT_W-1:0] status;
      logic [CNT_W-1:0]  count;
      logic              full;
      logic              empty;
   } rsp_meta_type;

endpackage

/* hdl/dq_ram.sv */
// ----------------------------------------------------------------------------
// dq_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module dq_ram #(
   parameter int DATA_W = 32,
   parameter int ADDR_W = 4,
   parameter int WORDS  = 16
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [DATA_W-1:0] wdata,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [WORDS];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

/* hdl/dq_ctrl.sv */
// ----------------------------------------------------------------------------
// dq_ctrl
// Ring pointer and fill count logic. Decodes each command into one memory
// access and registers the status, count and flags of the response.
// ----------------------------------------------------------------------------
module dq_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        cmd_valid,
   input  logic [dq_pkg::CMD_W-1:0]    cmd,
   input  logic [dq_pkg::DATA_W-1:0]   value,
   output dq_pkg::mem_req_type         mem_req,
   output dq_pkg::rsp_meta_type        meta
);

   localparam int SUM_W = dq_pkg::PTR_W + 2;

   logic [dq_pkg::PTR_W-1:0] head_ff, head_in;
   logic [dq_pkg::CNT_W-1:0] count_ff, count_in;
   dq_pkg::rsp_meta_type     meta_ff, meta_in;

   logic                     now_full;
   logic                     now_empty;
   logic [dq_pkg::PTR_W-1:0] head_dec;
   logic [dq_pkg::PTR_W-1:0] head_inc;
   logic [dq_pkg::PTR_W-1:0] tail_pos;
   logic [dq_pkg::PTR_W-1:0] last_pos;

   function automatic logic [dq_pkg::PTR_W-1:0] ring_add(
      input logic [dq_pkg::PTR_W-1:0] base,
      input logic [dq_pkg::CNT_W-1:0] off
   );
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(off);
      if (sum >= SUM_W'(dq_pkg::DEPTH)) begin
         sum = sum - SUM_W'(dq_pkg::DEPTH);
      end
      return sum[dq_pkg::PTR_W-1:0];
   endfunction

   always_comb begin
      now_full  = (count_ff == dq_pkg::CNT_W'(dq_pkg::DEPTH));
      now_empty = (count_ff == '0);
      head_dec = (head_ff == '0) ? dq_pkg::PTR_W'(dq_pkg::DEPTH - 1) : head_ff - 1'b1;
      head_inc = ring_add(head_ff, dq_pkg::CNT_W'(1));
      tail_pos = ring_add(head_ff, count_ff);
      last_pos = ring_add(head_ff, count_ff - 1'b1);
   end

   always_comb begin
      head_in         = head_ff;
      count_in        = count_ff;
      mem_req.we      = 1'b0;
      mem_req.addr    = head_ff;
      mem_req.wdata   = value;
      meta_in         = '0;
      meta_in.valid   = cmd_valid;
      meta_in.status  = dq_pkg::ST_OK;
      if (cmd_valid) begin
         unique case (cmd)
            dq_pkg::CMD_PUSH_FRONT: begin
               if (now_full) begin
                  meta_in.status = dq_pkg::ST_OVERFLOW;
               end else begin
                  mem_req.we   = 1'b1;
                  mem_req.addr = head_dec;
                  head_in      = head_dec;
                  count_in     = count_ff + 1'b1;
               end
            end
            dq_pkg::CMD_PUSH_BACK: begin
               if (now_full) begin
                  meta_in.status = dq_pkg::ST_OVERFLOW;
               end else begin
                  mem_req.we   = 1'b1;
                  mem_req.addr = tail_pos;
                  count_in     = count_ff + 1'b1;
               end
            end
            dq_pkg::CMD_POP_FRONT, dq_pkg::CMD_PEEK_FRONT: begin
               if (now_empty) begin
                  meta_in.status = dq_pkg::ST_UNDERFLOW;
               end else begin
                  meta_in.rd   = 1'b1;
                  mem_req.addr = head_ff;
                  if (cmd == dq_pkg::CMD_POP_FRONT) begin
                     head_in  = head_inc;
                     count_in = count_ff - 1'b1;
                  end
               end
            end
            dq_pkg::CMD_POP_BACK, dq_pkg::CMD_PEEK_BACK: begin
               if (now_empty) begin
                  meta_in.status = dq_pkg::ST_UNDERFLOW;
               end else begin
                  meta_in.rd   = 1'b1;
                  mem_req.addr = last_pos;
                  if (cmd == dq_pkg::CMD_POP_BACK) begin
                     count_in = count_ff - 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
      meta_in.count = count_in;
      meta_in.full  = (count_in == dq_pkg::CNT_W'(dq_pkg::DEPTH));
      meta_in.empty = (count_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         count_ff      <= '0;
         meta_ff.valid <= 1'b0;
      end else begin
         head_ff       <= head_in;
         count_ff      <= count_in;
         meta_ff.valid <= meta_in.valid;
      end
      meta_ff.rd     <= meta_in.rd;
      meta_ff.status <= meta_in.status;
      meta_ff.count  <= meta_in.count;
      meta_ff.full   <= meta_in.full;
      meta_ff.empty  <= meta_in.empty;
   end

   assign meta = meta_ff;

endmodule

/* hdl/double_ended_queue_core.sv */
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Bounded double-ended queue of 32-bit words held in a ring buffer.
// ----------------------------------------------------------------------------
// A command word is taken at a rising edge where start is high and busy is
// low. The commands push at the front or back, pop from the front or back,
// or peek at the front or back; value carries the word to push.
// Every command gives exactly one response word in the cycle after it is
// taken, marked by rsp_strobe for that single cycle. The response holds the
// word read, a status code, the count after the command, and the full and
// empty flags.
// One command is taken every cycle: the ring pointers update in the cycle
// of the command, and the single-port storage RAM carries one read or one
// write per command, with the read data registered into the response.
// busy is never raised.
// Reset clears the head pointer and the count, so the queue starts empty;
// the storage itself is not cleared. The receiver cannot stall responses.
// ----------------------------------------------------------------------------
module double_ended_queue_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [dq_pkg::CMD_W-1:0]          req_command,
   input  logic signed [dq_pkg::DATA_W-1:0]  req_value,
   output logic                              rsp_strobe,
   output logic signed [dq_pkg::DATA_W-1:0]  rsp_data,
   output logic [dq_pkg::STAT_W-1:0]         rsp_status,
   output logic [dq_pkg::CNT_W-1:0]          rsp_count,
   output logic                              rsp_is_full,
   output logic                              rsp_empty
);

   dq_pkg::mem_req_type       mem_req;
   dq_pkg::rsp_meta_type      meta;
   logic [dq_pkg::DATA_W-1:0] rdata;

   assign busy = 1'b0;

   dq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (start & ~busy),
      .cmd       (req_command),
      .value     (req_value),
      .mem_req   (mem_req),
      .meta      (meta)
   );

   dq_ram #(
      .DATA_W (dq_pkg::DATA_W),
      .ADDR_W (dq_pkg::PTR_W),
      .WORDS  (dq_pkg::DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (mem_req.we),
      .addr  (mem_req.addr),
      .wdata (mem_req.wdata),
      .rdata (rdata)
   );

   assign rsp_strobe   = meta.valid;
   assign rsp_data     = meta.rd ? rdata : '0;
   assign rsp_status   = meta.status;
   assign rsp_count    = meta.count;
   assign rsp_is_full  = meta.full;
   assign rsp_empty    = meta.empty;

endmodule

/* dv/double_ended_queue_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// double_ended_queue_core_tb
// Self-checking testbench for the bounded double-ended queue core.
// ----------------------------------------------------------------------------
// Commands are sent through the start/busy handshake with random gaps and
// back-to-back bursts. A behavioral copy of the queue predicts every response
// word, and a monitor compares each strobed response against the oldest
// prediction. Directed commands cover the empty and single-element cases and
// the data extremes. Fill-and-drain rounds reach the full boundary and the
// overflow and underflow cases. A random mix with a drifting push rate then
// lets the occupancy wander between empty and full.
// ----------------------------------------------------------------------------
module double_ended_queue_core_tb;

   localparam logic [dq_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd6;
   localparam logic [dq_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;
   localparam logic signed [dq_pkg::DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
   localparam logic signed [dq_pkg::DATA_W-1:0] WORD_MAX = 32'sh7fff_ffff;

   typedef struct {
      logic signed [dq_pkg::DATA_W-1:0] data;
      logic [dq_pkg::STAT_W-1:0]        status;
      logic [dq_pkg::CNT_W-1:0]         count;
      logic                             is_full;
      logic                             empty;
   } deque_reply_type;

   logic                             clock;
   logic                             reset;
   logic                             start;
   logic                             busy;
   logic [dq_pkg::CMD_W-1:0]         req_command;
   logic signed [dq_pkg::DATA_W-1:0] req_value;
   logic                             rsp_strobe;
   logic signed [dq_pkg::DATA_W-1:0] rsp_data;
   logic [dq_pkg::STAT_W-1:0]        rsp_status;
   logic [dq_pkg::CNT_W-1:0]         rsp_count;
   logic                             rsp_is_full;
   logic                             rsp_empty;

   logic signed [dq_pkg::DATA_W-1:0] ring_words [dq_pkg::DEPTH];
   int                               front_slot;
   int                               held_words;
   deque_reply_type                  pending_replies [$];
   int                               mismatch_count;
   int                               burst_left;
   int                               push_percent;

   double_ended_queue_core uut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_command  (req_command),
      .req_value    (req_value),
      .rsp_strobe   (rsp_strobe),
      .rsp_data     (rsp_data),
      .rsp_status   (rsp_status),
      .rsp_count    (rsp_count),
      .rsp_is_full  (rsp_is_full),
      .rsp_empty    (rsp_empty)
   );

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic deque_reply_type apply_deque_command(
      logic [dq_pkg::CMD_W-1:0] cmd,
      logic signed [dq_pkg::DATA_W-1:0] word
   );
      deque_reply_type reply;
      reply.data   = '0;
      reply.status = dq_pkg::ST_OK;
      case (cmd)
         dq_pkg::CMD_PUSH_FRONT, dq_pkg::CMD_PUSH_BACK: begin
            if (held_words == dq_pkg::DEPTH) begin
               reply.status = dq_pkg::ST_OVERFLOW;
            end else if (cmd == dq_pkg::CMD_PUSH_FRONT) begin
               front_slot = (front_slot + dq_pkg::DEPTH - 1) % dq_pkg::DEPTH;
               ring_words[front_slot] = word;
               held_words++;
            end else begin
               ring_words[(front_slot + held_words) % dq_pkg::DEPTH] = word;
               held_words++;
            end
         end
         dq_pkg::CMD_POP_FRONT, dq_pkg::CMD_PEEK_FRONT: begin
            if (held_words == 0) begin
               reply.status = dq_pkg::ST_UNDERFLOW;
            end else begin
               reply.data = ring_words[front_slot];
               if (cmd == dq_pkg::CMD_POP_FRONT) begin
                  front_slot = (front_slot + 1) % dq_pkg::DEPTH;
                  held_words--;
               end
            end
         end
         dq_pkg::CMD_POP_BACK, dq_pkg::CMD_PEEK_BACK: begin
            if (held_words == 0) begin
               reply.status = dq_pkg::ST_UNDERFLOW;
            end else begin
               reply.data = ring_words[(front_slot + held_words - 1) % dq_pkg::DEPTH];
               if (cmd == dq_pkg::CMD_POP_BACK) begin
                  held_words--;
               end
            end
         end
         default: begin
         end
      endcase
      reply.count   = held_words[dq_pkg::CNT_W-1:0];
      reply.is_full = (held_words == dq_pkg::DEPTH);
      reply.empty   = (held_words == 0);
      return reply;
   endfunction

   function automatic int sender_gap();
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         burst_left = $urandom_range(8, 30);
         return 0;
      end
      return $urandom_range(0, 14);
   endfunction

   function automatic logic signed [dq_pkg::DATA_W-1:0] random_word();
      case ($urandom_range(0, 15))
         0: return WORD_MIN;
         1: return WORD_MAX;
         2: return '0;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   // Called at a rising edge; returns at the edge where the word is taken.
   task automatic send_word(input logic [dq_pkg::CMD_W-1:0] cmd,
                            input logic signed [dq_pkg::DATA_W-1:0] word);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_command <= cmd;
      req_value   <= word;
      do @(posedge clock); while (busy !== 1'b0);
      pending_replies.push_back(apply_deque_command(cmd, word));
   endtask

   task automatic wait_for_replies();
      start <= 1'b0;
      do @(posedge clock); while (pending_replies.size() != 0);
   endtask

   task automatic report_field(input string field, input logic [dq_pkg::DATA_W-1:0] want,
                               input logic [dq_pkg::DATA_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      deque_reply_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_replies.size() == 0) begin
            $display("%0t: response word with none expected, data %0h status %0d",
                     $time, rsp_data, rsp_status);
            mismatch_count++;
         end else begin
            want = pending_replies.pop_front();
            report_field("data", want.data, rsp_data);
            report_field("status", want.status, rsp_status);
            report_field("count", want.count, rsp_count);
            report_field("is_full", want.is_full, rsp_is_full);
            report_field("empty", want.empty, rsp_empty);
         end
      end
   end

   task automatic test_empty_queue();
      send_word(dq_pkg::CMD_POP_FRONT, $urandom);
      send_word(dq_pkg::CMD_POP_BACK, $urandom);
      send_word(dq_pkg::CMD_PEEK_FRONT, $urandom);
      send_word(dq_pkg::CMD_PEEK_BACK, $urandom);
      send_word(CMD_SPARE_LO, $urandom);
      send_word(CMD_SPARE_HI, $urandom);
   endtask

   task automatic test_single_and_pair();
      send_word(dq_pkg::CMD_PUSH_FRONT, WORD_MIN);
      send_word(dq_pkg::CMD_PEEK_BACK, '0);
      send_word(dq_pkg::CMD_POP_BACK, '1);
      send_word(dq_pkg::CMD_PEEK_FRONT, '0);
      send_word(dq_pkg::CMD_PUSH_BACK, WORD_MAX);
      send_word(dq_pkg::CMD_PUSH_FRONT, '1);
      send_word(dq_pkg::CMD_PEEK_FRONT, '0);
      send_word(dq_pkg::CMD_PEEK_BACK, '0);
      send_word(CMD_SPARE_HI, '0);
      send_word(dq_pkg::CMD_POP_FRONT, '0);
      send_word(dq_pkg::CMD_POP_FRONT, '0);
      send_word(dq_pkg::CMD_POP_BACK, '0);
   endtask

   task automatic test_fill_and_drain(input int rounds);
      for (int r = 0; r < rounds; r++) begin
         while (held_words < dq_pkg::DEPTH) begin
            send_word($urandom_range(0, 1) ? dq_pkg::CMD_PUSH_FRONT : dq_pkg::CMD_PUSH_BACK,
                      random_word());
         end
         repeat ($urandom_range(1, 3)) begin
            send_word($urandom_range(0, 1) ? dq_pkg::CMD_PUSH_FRONT : dq_pkg::CMD_PUSH_BACK,
                      random_word());
         end
         send_word(dq_pkg::CMD_PEEK_FRONT, $urandom);
         send_word(dq_pkg::CMD_PEEK_BACK, $urandom);
         send_word($urandom_range(0, 1) ? CMD_SPARE_LO : CMD_SPARE_HI, $urandom);
         while (held_words > 0) begin
            case ($urandom_range(0, 5))
               0: send_word(dq_pkg::CMD_PEEK_FRONT, $urandom);
               1: send_word(dq_pkg::CMD_PEEK_BACK, $urandom);
               2, 3: send_word(dq_pkg::CMD_POP_FRONT, $urandom);
               default: send_word(dq_pkg::CMD_POP_BACK, $urandom);
            endcase
         end
         repeat ($urandom_range(1, 2)) begin
            send_word($urandom_range(0, 1) ? dq_pkg::CMD_POP_FRONT : dq_pkg::CMD_POP_BACK,
                      $urandom);
         end
         if (r == 0) begin
            wait_for_replies();
         end
      end
   endtask

   task automatic test_random_mix(input int items);
      int pick;
      for (int n = 0; n < items; n++) begin
         if (n % 40 == 0) begin
            push_percent = $urandom_range(25, 75);
         end
         if ($urandom_range(0, 59) == 0) begin
            wait_for_replies();
         end
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            send_word($urandom_range(0, 1) ? CMD_SPARE_LO : CMD_SPARE_HI, $urandom);
         end else if (pick < 4 + push_percent) begin
            send_word($urandom_range(0, 1) ? dq_pkg::CMD_PUSH_FRONT : dq_pkg::CMD_PUSH_BACK,
                      random_word());
         end else begin
            case ($urandom_range(0, 5))
               0: send_word(dq_pkg::CMD_PEEK_FRONT, $urandom);
               1: send_word(dq_pkg::CMD_PEEK_BACK, $urandom);
               2, 3: send_word(dq_pkg::CMD_POP_FRONT, $urandom);
               default: send_word(dq_pkg::CMD_POP_BACK, $urandom);
            endcase
         end
      end
   endtask

   initial begin
      int drain_cycles;
      mismatch_count = 0;
      burst_left     = 0;
      push_percent   = 50;
      front_slot     = 0;
      held_words     = 0;
      reset       <= 1'b1;
      start       <= 1'b0;
      req_command <= dq_pkg::CMD_PUSH_FRONT;
      req_value   <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_empty_queue();
      test_single_and_pair();
      wait_for_replies();
      test_fill_and_drain(6);
      test_random_mix(400);

      start <= 1'b0;
      drain_cycles = 0;
      while (pending_replies.size() != 0 && drain_cycles < 1000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (4) @(posedge clock);
      if (pending_replies.size() != 0) begin
         $display("%0t: %0d response words never arrived", $time, pending_replies.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
